// ----- rtl/core/pps_pkg.sv -----
// Shared types and constants for the polygon plane splitter.
// No dependencies; used by the interfaces, the fraction divider and the top level.
package pps_pkg;

  localparam int COORD_W = 32;
  localparam int DIST_W  = 64;
  localparam int THR_W   = 31;
  localparam int FRAC_W  = 31;   // Q0.30 fraction, one guard bit for t == 1.0
  localparam int FRAC_SH = 30;
  localparam int CIDX_W  = 3;
  localparam int MAX_RESULTS = 48;  // piece vertices kept per polygon

  // config register indexes
  localparam logic [CIDX_W-1:0] CFG_NX  = 3'd0;
  localparam logic [CIDX_W-1:0] CFG_NY  = 3'd1;
  localparam logic [CIDX_W-1:0] CFG_NZ  = 3'd2;
  localparam logic [CIDX_W-1:0] CFG_OFS = 3'd3;
  localparam logic [CIDX_W-1:0] CFG_THR = 3'd4;

  // polygon classification
  localparam logic [1:0] ST_FRONT    = 2'd0;
  localparam logic [1:0] ST_BACK     = 2'd1;
  localparam logic [1:0] ST_COPLANAR = 2'd2;
  localparam logic [1:0] ST_SPLIT    = 2'd3;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } vertex_t;

  typedef struct packed {
    vertex_t                  v;
    logic signed [DIST_W-1:0] d;
  } entry_t;

  function automatic logic signed [COORD_W-1:0] vtx_get(vertex_t v, logic [1:0] k);
    logic signed [COORD_W-1:0] r;
    case (k)
      2'd0:    r = v.x;
      2'd1:    r = v.y;
      default: r = v.z;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/core/pps_in_if.sv -----
// Input channel: one polygon vertex per item.
// Depends on pps_pkg for widths.
interface pps_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [pps_pkg::COORD_W-1:0] vertex_x;
  logic signed [pps_pkg::COORD_W-1:0] vertex_y;
  logic signed [pps_pkg::COORD_W-1:0] vertex_z;
  logic                               last_vertex;
  logic                               want_pieces;

  modport source(output valid, vertex_x, vertex_y, vertex_z, last_vertex, want_pieces,
                 input ready);
  modport sink(input valid, vertex_x, vertex_y, vertex_z, last_vertex, want_pieces,
               output ready);
endinterface

// ----- rtl/core/pps_out_if.sv -----
// Result channel: status items and piece vertices.
// Depends on pps_pkg for widths.
interface pps_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [pps_pkg::COORD_W-1:0] out_x;
  logic signed [pps_pkg::COORD_W-1:0] out_y;
  logic signed [pps_pkg::COORD_W-1:0] out_z;
  logic                               has_vertex;
  logic                               piece;
  logic [1:0]                         split_status;
  logic                               last_result;

  modport source(output valid, out_x, out_y, out_z, has_vertex, piece, split_status,
                 last_result, input ready);
  modport sink(input valid, out_x, out_y, out_z, has_vertex, piece, split_status,
               last_result, output ready);
endinterface

// ----- rtl/core/pps_cfg_if.sv -----
// Configuration write channel: register index and data.
// Depends on pps_pkg for widths.
interface pps_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [pps_pkg::CIDX_W-1:0]        index;
  logic [pps_pkg::COORD_W-1:0]       data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ----- rtl/core/pps_ram.sv -----
// Generic single write, single read RAM with registered read data.
// No dependencies.
module pps_ram #(
  parameter int WIDTH = 160,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

// ----- rtl/core/pps_frac.sv -----
// Edge cut fraction t = |dw| / |dw - dv| in Q0.30: normalize one bit a cycle,
// then restoring division one quotient bit a cycle. Depends on pps_pkg.
module pps_frac (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic signed [pps_pkg::DIST_W-1:0]  dw,
  input  logic signed [pps_pkg::DIST_W-1:0]  dv,
  output logic                               done_r,
  output logic [pps_pkg::FRAC_W-1:0]         t_r
);

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_NORM = 2'd1;
  localparam logic [1:0] F_DIV  = 2'd2;

  logic [1:0]                        fst_r;
  logic [pps_pkg::DIST_W-1:0]        a_r, b_r;
  logic [31:0]                       rem_r;
  logic [pps_pkg::FRAC_W-2:0]        q_r;
  logic [4:0]                        cnt_r;
  logic                              bz_r;
  logic signed [pps_pkg::DIST_W-1:0] den;
  logic [32:0]                       rem2;
  logic                              ge;

  assign den  = dw - dv;
  assign rem2 = (cnt_r == 5'd0) ? {1'b0, rem_r} : {rem_r, 1'b0};
  assign ge   = rem2 >= {1'b0, b_r[31:0]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fst_r  <= F_IDLE;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (fst_r)
        F_IDLE: begin
          if (start) begin
            a_r   <= dw[pps_pkg::DIST_W-1] ? -dw : dw;
            b_r   <= den[pps_pkg::DIST_W-1] ? -den : den;
            fst_r <= F_NORM;
          end
        end
        F_NORM: begin
          if (b_r[pps_pkg::DIST_W-1:32] != '0) begin
            a_r <= a_r >> 1;
            b_r <= b_r >> 1;
          end else begin
            rem_r <= (a_r > b_r) ? b_r[31:0] : a_r[31:0];
            bz_r  <= b_r == '0;
            cnt_r <= '0;
            fst_r <= F_DIV;
          end
        end
        F_DIV: begin
          rem_r <= ge ? 32'(rem2 - {1'b0, b_r[31:0]}) : rem2[31:0];
          q_r   <= {q_r[pps_pkg::FRAC_W-3:0], ge};
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == 5'(pps_pkg::FRAC_W - 1)) begin
            t_r    <= bz_r ? '0 : {q_r, ge};
            done_r <= 1'b1;
            fst_r  <= F_IDLE;
          end
        end
        default: fst_r <= F_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/core/polygon_plane_split.sv -----
// Polygon plane split. A vertex item is accepted, then goes through three multiply and
// accumulate pairs on the shared multiplier and a store write; in_ready is high only when idle.
// Piece emission walks the store twice (front, then back), reloading the closing vertex at
// the start of each pass; each crossing edge adds normalize shifts, a 31-step divider and
// 3 multiplies.
// Reset (synchronous, rst_n low) clears control, counts and flags and loads the plane
// registers' reset values; the vertex store holds no reset value.
module polygon_plane_split #(
  parameter int MAX_VERTS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  pps_in_if.sink     in_ch,
  pps_out_if.source  out_ch,
  pps_cfg_if.sink    cfg_ch
);

  localparam int AW = $clog2(MAX_VERTS);
  localparam int CW = $clog2(MAX_VERTS + 1);
  localparam int EW = $bits(pps_pkg::entry_t);

  // sequencer codes
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_MUL    = 4'd1;
  localparam logic [3:0] S_ACC    = 4'd2;
  localparam logic [3:0] S_DIST   = 4'd3;
  localparam logic [3:0] S_CLASS  = 4'd4;
  localparam logic [3:0] S_RDP    = 4'd5;
  localparam logic [3:0] S_RDPW   = 4'd6;
  localparam logic [3:0] S_RDC    = 4'd7;
  localparam logic [3:0] S_RDCW   = 4'd8;
  localparam logic [3:0] S_CHK    = 4'd9;
  localparam logic [3:0] S_FRAC   = 4'd10;
  localparam logic [3:0] S_CMUL   = 4'd11;
  localparam logic [3:0] S_CADD   = 4'd12;
  localparam logic [3:0] S_ICEMIT = 4'd13;
  localparam logic [3:0] S_VTX    = 4'd14;
  localparam logic [3:0] S_FIN    = 4'd15;

  // plane registers
  logic signed [31:0] nx_r, ny_r, nz_r, ofs_r;
  logic [pps_pkg::THR_W-1:0] thr_r;

  logic [3:0]  st_r;
  logic [1:0]  k_r;
  logic        last_r, want_r, pass_r;
  logic [CW-1:0] count_r, n_r;
  logic [AW-1:0] i_r;
  logic        seen_f_r, seen_b_r;
  pps_pkg::vertex_t vtx_r;
  logic signed [63:0] acc_r, mprod_r;
  pps_pkg::entry_t prev_r, cur_r;
  logic signed [31:0] ic_r [3];

  // one-item hold so the final piece vertex can carry last_result
  logic             hold_valid_r, hold_piece_r;
  pps_pkg::vertex_t hold_r;
  logic [5:0]       nemit_r;   // piece vertices emitted so far
  logic             emit_ok;

  // output register
  logic             out_valid_r;
  pps_pkg::vertex_t out_v_r;
  logic             out_has_r, out_piece_r, out_last_r;
  logic [1:0]       out_st_r;

  // RAM
  logic          ram_we;
  logic [AW-1:0] ram_raddr;
  logic [EW-1:0] ram_rdata;
  pps_pkg::entry_t ram_wentry;

  // fraction unit
  logic                       frac_start, frac_done;
  logic [pps_pkg::FRAC_W-1:0] frac_t;

  // shared multiplier
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;
  logic signed [31:0] nsel, csel, psel, vsel;

  logic [CW-1:0] n_m1;
  logic [AW-1:0] last_idx;
  logic          out_free, cur_front, prev_front, cur_mine;
  logic signed [63:0] thr_pos, thr_neg, bias, qv;
  logic [1:0]    status;
  logic          emit_en;
  pps_pkg::vertex_t emit_v, ic_v;

  logic             out_load;
  pps_pkg::vertex_t out_v_nxt;
  logic             out_has_nxt, out_piece_nxt, out_last_nxt;
  logic [1:0]       out_st_nxt;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = (st_r == S_IDLE);
  assign out_free     = !out_valid_r || out_ch.ready;

  assign n_m1     = n_r - 1'b1;
  assign last_idx = n_m1[AW-1:0];

  assign thr_pos = $signed({33'd0, thr_r});
  assign thr_neg = -thr_pos;

  assign cur_front  = !cur_r.d[63];
  assign prev_front = !prev_r.d[63];
  assign cur_mine   = cur_front != pass_r;  // pass 0 takes front vertices

  always_comb begin
    if (!seen_f_r) begin
      status = seen_b_r ? pps_pkg::ST_BACK : pps_pkg::ST_COPLANAR;
    end else if (!seen_b_r) begin
      status = pps_pkg::ST_FRONT;
    end else begin
      status = pps_pkg::ST_SPLIT;
    end
  end

  // multiplier operands: distance products, or edge delta times cut fraction
  always_comb begin
    case (k_r)
      2'd0:    nsel = nx_r;
      2'd1:    nsel = ny_r;
      default: nsel = nz_r;
    endcase
    csel = pps_pkg::vtx_get(cur_r.v, k_r);
    psel = pps_pkg::vtx_get(prev_r.v, k_r);
    vsel = pps_pkg::vtx_get(vtx_r, k_r);
    if (st_r == S_MUL) begin
      mul_a = {vsel[31], vsel};
      mul_b = {nsel[31], nsel};
    end else begin
      mul_a = {csel[31], csel} - {psel[31], psel};
      mul_b = {2'b00, frac_t};
    end
  end
  assign mul_p = mul_a * mul_b;

  // truncate toward zero on the divide by 2^30
  assign bias = mprod_r[63] ? 64'sd1073741823 : 64'sd0;
  assign qv   = (mprod_r + bias) >>> pps_pkg::FRAC_SH;

  assign ic_v = '{x: ic_r[0], y: ic_r[1], z: ic_r[2]};

  assign ram_we     = (st_r == S_DIST);
  assign ram_wentry = '{v: vtx_r, d: acc_r};
  assign ram_raddr  = (st_r == S_RDP) ? last_idx : i_r;

  assign frac_start = (st_r == S_CHK) && (cur_front != prev_front);

  // piece vertices past the result limit are dropped
  assign emit_ok = nemit_r < 6'(pps_pkg::MAX_RESULTS);
  assign emit_en = emit_ok && out_free &&
                   ((st_r == S_ICEMIT) || ((st_r == S_VTX) && cur_mine));
  assign emit_v  = (st_r == S_ICEMIT) ? ic_v : cur_r.v;

  // output register loads: status item, hold pushed by a new piece vertex, or final flush
  always_comb begin
    out_load      = 1'b0;
    out_v_nxt     = hold_r;
    out_has_nxt   = 1'b1;
    out_piece_nxt = hold_piece_r;
    out_st_nxt    = pps_pkg::ST_SPLIT;
    out_last_nxt  = 1'b0;
    if (st_r == S_CLASS && out_free && !(status == pps_pkg::ST_SPLIT && want_r)) begin
      out_load      = 1'b1;
      out_v_nxt     = '0;
      out_has_nxt   = 1'b0;
      out_piece_nxt = 1'b0;
      out_st_nxt    = status;
      out_last_nxt  = 1'b1;
    end else if (emit_en && hold_valid_r) begin
      out_load = 1'b1;
    end else if (st_r == S_FIN && out_free) begin
      out_load     = 1'b1;
      out_last_nxt = 1'b1;
    end
  end

  pps_ram #(.WIDTH(EW), .DEPTH(MAX_VERTS)) u_store (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (count_r[AW-1:0]),
    .wdata   (ram_wentry),
    .raddr   (ram_raddr),
    .rdata_r (ram_rdata)
  );

  pps_frac u_frac (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (frac_start),
    .dw     (prev_r.d),
    .dv     (cur_r.d),
    .done_r (frac_done),
    .t_r    (frac_t)
  );

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nx_r  <= '0;
      ny_r  <= '0;
      nz_r  <= 32'sd65536;
      ofs_r <= '0;
      thr_r <= 31'd16384;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        pps_pkg::CFG_NX:  nx_r  <= cfg_ch.data;
        pps_pkg::CFG_NY:  ny_r  <= cfg_ch.data;
        pps_pkg::CFG_NZ:  nz_r  <= cfg_ch.data;
        pps_pkg::CFG_OFS: ofs_r <= cfg_ch.data;
        pps_pkg::CFG_THR: thr_r <= cfg_ch.data[pps_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
      out_v_r     <= out_v_nxt;
      out_has_r   <= out_has_nxt;
      out_piece_r <= out_piece_nxt;
      out_st_r    <= out_st_nxt;
      out_last_r  <= out_last_nxt;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.out_x        = out_v_r.x;
  assign out_ch.out_y        = out_v_r.y;
  assign out_ch.out_z        = out_v_r.z;
  assign out_ch.has_vertex   = out_has_r;
  assign out_ch.piece        = out_piece_r;
  assign out_ch.split_status = out_st_r;
  assign out_ch.last_result  = out_last_r;

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= S_IDLE;
      count_r      <= '0;
      seen_f_r     <= 1'b0;
      seen_b_r     <= 1'b0;
      hold_valid_r <= 1'b0;
      nemit_r      <= '0;
    end else begin
      if (emit_en) begin
        hold_r       <= emit_v;
        hold_piece_r <= pass_r;
        hold_valid_r <= 1'b1;
        nemit_r      <= nemit_r + 6'd1;
      end
      case (st_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            vtx_r  <= '{x: in_ch.vertex_x, y: in_ch.vertex_y, z: in_ch.vertex_z};
            last_r <= in_ch.last_vertex;
            want_r <= in_ch.want_pieces;
            acc_r  <= -64'(ofs_r);
            k_r    <= '0;
            if (count_r < CW'(MAX_VERTS)) begin
              st_r <= S_MUL;
            end else if (in_ch.last_vertex) begin
              st_r <= S_CLASS;
            end
          end
        end
        S_MUL: begin
          mprod_r <= mul_p[63:0];
          st_r    <= S_ACC;
        end
        S_ACC: begin
          acc_r <= acc_r + (mprod_r >>> 16);  // floor of the Q32.32 product to Q16.16
          if (k_r == 2'd2) begin
            st_r <= S_DIST;
          end else begin
            k_r  <= k_r + 2'd1;
            st_r <= S_MUL;
          end
        end
        S_DIST: begin
          if (acc_r > thr_pos) seen_f_r <= 1'b1;
          if (acc_r < thr_neg) seen_b_r <= 1'b1;
          count_r <= count_r + 1'b1;
          st_r    <= last_r ? S_CLASS : S_IDLE;
        end
        S_CLASS: begin
          if (status == pps_pkg::ST_SPLIT && want_r) begin
            n_r      <= count_r;
            pass_r   <= 1'b0;
            count_r  <= '0;
            seen_f_r <= 1'b0;
            seen_b_r <= 1'b0;
            nemit_r  <= '0;
            st_r     <= S_RDP;
          end else if (out_free) begin
            count_r  <= '0;
            seen_f_r <= 1'b0;
            seen_b_r <= 1'b0;
            st_r     <= S_IDLE;
          end
        end
        // each pass starts with the closing edge: previous vertex is the last one
        S_RDP:  st_r <= S_RDPW;
        S_RDPW: begin
          prev_r <= ram_rdata;
          i_r    <= '0;
          st_r   <= S_RDC;
        end
        S_RDC:  st_r <= S_RDCW;
        S_RDCW: begin
          cur_r <= ram_rdata;
          st_r  <= S_CHK;
        end
        S_CHK: begin
          st_r <= (cur_front != prev_front) ? S_FRAC : S_VTX;
        end
        S_FRAC: begin
          k_r <= '0;
          if (frac_done) st_r <= S_CMUL;
        end
        S_CMUL: begin
          mprod_r <= mul_p[63:0];
          st_r    <= S_CADD;
        end
        S_CADD: begin
          ic_r[k_r] <= psel + qv[31:0];
          if (k_r == 2'd2) begin
            st_r <= S_ICEMIT;
          end else begin
            k_r  <= k_r + 2'd1;
            st_r <= S_CMUL;
          end
        end
        S_ICEMIT: begin
          if (out_free) st_r <= S_VTX;
        end
        S_VTX: begin
          if (!cur_mine || out_free) begin
            prev_r <= cur_r;
            if (i_r == last_idx) begin
              if (!pass_r) begin
                pass_r <= 1'b1;
                st_r   <= S_RDP;
              end else begin
                st_r <= S_FIN;
              end
            end else begin
              i_r  <= i_r + 1'b1;
              st_r <= S_RDC;
            end
          end
        end
        S_FIN: begin
          if (out_free) begin
            hold_valid_r <= 1'b0;
            st_r         <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

endmodule
